>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CTLL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CTLL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ctll_pkg.sv
// Package with types, token codes and classification functions of the lexer.
`default_nettype none
package ctll_pkg;
	localparam int PosW = 16;
	localparam int KwChars = 9;
	localparam int KwIdxW = $clog2(KwChars);
	localparam int KwCount = 35;
	localparam int QDepth = 8;
	localparam int QPtrW = $clog2(QDepth);
	localparam int QCntW = QPtrW + 1;
	localparam logic [PosW-1:0] PosMax = '1;

	localparam logic [6:0] T_UNKNOWN = 7'd0;
	localparam logic [6:0] T_EOF = 7'd1;
	localparam logic [6:0] T_BAD_STR = 7'd2;
	localparam logic [6:0] T_BAD_CHR = 7'd3;
	localparam logic [6:0] T_INT = 7'd4;
	localparam logic [6:0] T_FLOAT = 7'd5;
	localparam logic [6:0] T_STR = 7'd6;
	localparam logic [6:0] T_CHR = 7'd7;
	localparam logic [6:0] T_IDENT = 7'd8;
	localparam logic [6:0] T_KW_BASE = 7'd9;
	localparam logic [6:0] T_DOT = 7'd69;

	localparam logic [KwChars*8-1:0] KW_TEXT [KwCount] = '{
		"class", "public", "private", "protected", "static", "void", "int",
		"float", "double", "string", "bool", "char", "if", "else", "while",
		"for", "foreach", "return", "new", "this", "base", "namespace", "using",
		"true", "false", "null", "try", "catch", "finally", "throw",
		"interface", "abstract", "virtual", "override", "sealed"
	};
	localparam int KW_LEN [KwCount] = '{
		5, 6, 7, 9, 6, 4, 3, 5, 6, 6, 4, 4, 2, 4, 5, 3, 7, 6, 3, 4, 4, 9, 5,
		4, 5, 4, 3, 5, 7, 5, 9, 8, 7, 8, 6
	};

	typedef enum logic [3:0] {
		PH_IDLE, PH_IDENT, PH_INT, PH_INT_DOT, PH_FRAC, PH_OP, PH_LINE_CMT,
		PH_BLOCK_CMT, PH_BLOCK_STAR, PH_STR, PH_STR_ESC, PH_CHR_OPEN,
		PH_CHR_ESC, PH_CHR_CLOSE
	} phase_t;

	typedef struct packed {
		logic [6:0] ttype;
		logic [PosW-1:0] line;
		logic [PosW-1:0] col;
		logic [PosW-1:0] len;
		logic last;
	} tok_t;

	typedef struct packed {
		logic [1:0] num;
		tok_t [2:0] tok;
	} push_t;

	function automatic logic [PosW-1:0] sat_inc(logic [PosW-1:0] v);
		return (v == PosMax) ? PosMax : v + 1'b1;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [6:0] single_code(logic [7:0] c);
		logic [6:0] r;
		case (c)
			"+": r = 7'd54;
			"-": r = 7'd55;
			"*": r = 7'd56;
			"/": r = 7'd57;
			"%": r = 7'd58;
			"=": r = 7'd59;
			"!": r = 7'd60;
			"<": r = 7'd61;
			">": r = 7'd62;
			"&": r = 7'd63;
			"|": r = 7'd64;
			"^": r = 7'd65;
			"~": r = 7'd66;
			";": r = 7'd67;
			",": r = 7'd68;
			".": r = T_DOT;
			"(": r = 7'd70;
			")": r = 7'd71;
			"{": r = 7'd72;
			"}": r = 7'd73;
			"[": r = 7'd74;
			"]": r = 7'd75;
			default: r = T_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] pair_code(logic [7:0] h, logic [7:0] c);
		logic [6:0] r;
		r = T_UNKNOWN;
		if (h == "+" && c == "+") r = 7'd44;
		if (h == "-" && c == "-") r = 7'd45;
		if (h == "+" && c == "=") r = 7'd46;
		if (h == "-" && c == "=") r = 7'd47;
		if (h == "=" && c == "=") r = 7'd48;
		if (h == "!" && c == "=") r = 7'd49;
		if (h == "<" && c == "=") r = 7'd50;
		if (h == ">" && c == "=") r = 7'd51;
		if (h == "&" && c == "&") r = 7'd52;
		if (h == "|" && c == "|") r = 7'd53;
		return r;
	endfunction

	function automatic logic [6:0] kw_lookup(logic [KwChars-1:0][7:0] kb,
			logic [PosW-1:0] len);
		logic [6:0] code;
		logic ok;
		code = T_IDENT;
		for (int i = 0; i < KwCount; i++) begin
			ok = (len == PosW'(KW_LEN[i]));
			for (int j = 0; j < KwChars; j++) begin
				if (j < KW_LEN[i]) begin
					if (kb[j] != KW_TEXT[i][(KW_LEN[i]-1-j)*8 +: 8]) ok = 1'b0;
				end
			end
			if (ok && code == T_IDENT) code = T_KW_BASE + 7'(i);
		end
		return code;
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/ctll_front.sv
// Front part: accepts source beats, runs the scan state machine and emits token bundles.
`default_nettype none
module ctll_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic src_valid,
	output logic src_stall,
	input wire logic [7:0] char_code,
	input wire logic mode,
	input wire logic room,
	output ctll_pkg::push_t push
);
	import ctll_pkg::*;

	phase_t phase_q, nphase;
	logic [PosW-1:0] len_q, nlen, line_q, nline, col_q, ncol;
	logic [PosW-1:0] tsl_q, ntsl, tsc_q, ntsc;
	logic [7:0] held_q, nheld;
	logic [KwChars-1:0][7:0] kw_q;
	logic kw_we;
	logic [KwIdxW-1:0] kw_idx;
	logic accept, restart, p_v, d_v, t_v;
	logic [6:0] p_type;
	logic [PosW-1:0] p_len, dot_col;
	logic [PosW:0] dot_sum;
	tok_t t_tok;
	tok_t [2:0] slot;
	logic [1:0] n;

	assign accept = src_valid && room;
	assign src_stall = !room;
	assign dot_sum = {1'b0, tsc_q} + {1'b0, len_q};
	assign dot_col = dot_sum[PosW] ? PosMax : dot_sum[PosW-1:0];

	always_comb begin
		nphase = phase_q;
		nlen = len_q;
		ntsl = tsl_q;
		ntsc = tsc_q;
		nheld = held_q;
		nline = line_q;
		ncol = col_q;
		kw_we = 1'b0;
		kw_idx = '0;
		restart = 1'b0;
		p_v = 1'b0;
		p_type = T_INT;
		p_len = len_q;
		d_v = 1'b0;
		t_v = 1'b0;
		t_tok = '0;
		if (mode) begin
			case (phase_q)
				PH_IDENT: begin
					p_v = 1'b1;
					p_type = kw_lookup(kw_q, len_q);
				end
				PH_INT: p_v = 1'b1;
				PH_INT_DOT: begin
					p_v = 1'b1;
					d_v = 1'b1;
				end
				PH_FRAC: begin
					p_v = 1'b1;
					p_type = T_FLOAT;
				end
				PH_OP: begin
					p_v = 1'b1;
					p_type = single_code(held_q);
				end
				PH_STR, PH_STR_ESC: begin
					p_v = 1'b1;
					p_type = T_BAD_STR;
				end
				PH_CHR_OPEN, PH_CHR_ESC, PH_CHR_CLOSE: begin
					p_v = 1'b1;
					p_type = T_BAD_CHR;
				end
				default: ;
			endcase
			t_v = 1'b1;
			t_tok = '{ttype: T_EOF, line: line_q, col: col_q, len: '0, last: 1'b0};
			nphase = PH_IDLE;
			nlen = '0;
			nline = PosW'(1);
			ncol = PosW'(1);
		end else begin
			case (phase_q)
				PH_IDENT: begin
					if (is_alpha(char_code) || is_digit(char_code)) begin
						if (len_q < PosW'(KwChars)) begin
							kw_we = 1'b1;
							kw_idx = len_q[KwIdxW-1:0];
						end
						nlen = sat_inc(len_q);
					end else begin
						p_v = 1'b1;
						p_type = kw_lookup(kw_q, len_q);
						restart = 1'b1;
					end
				end
				PH_INT: begin
					if (is_digit(char_code)) nlen = sat_inc(len_q);
					else if (char_code == ".") nphase = PH_INT_DOT;
					else begin
						p_v = 1'b1;
						restart = 1'b1;
					end
				end
				PH_INT_DOT: begin
					if (is_digit(char_code)) begin
						nlen = sat_inc(sat_inc(len_q));
						nphase = PH_FRAC;
					end else begin
						p_v = 1'b1;
						d_v = 1'b1;
						restart = 1'b1;
					end
				end
				PH_FRAC: begin
					if (is_digit(char_code)) nlen = sat_inc(len_q);
					else begin
						p_v = 1'b1;
						p_type = T_FLOAT;
						restart = 1'b1;
					end
				end
				PH_OP: begin
					if (held_q == "/" && char_code == "/") nphase = PH_LINE_CMT;
					else if (held_q == "/" && char_code == "*") nphase = PH_BLOCK_CMT;
					else if (pair_code(held_q, char_code) != T_UNKNOWN) begin
						nlen = PosW'(2);
						p_v = 1'b1;
						p_type = pair_code(held_q, char_code);
						p_len = PosW'(2);
						nphase = PH_IDLE;
					end else begin
						p_v = 1'b1;
						p_type = single_code(held_q);
						restart = 1'b1;
					end
				end
				PH_LINE_CMT: if (char_code == 8'h0A) nphase = PH_IDLE;
				PH_BLOCK_CMT: if (char_code == "*") nphase = PH_BLOCK_STAR;
				PH_BLOCK_STAR: begin
					if (char_code == "/") nphase = PH_IDLE;
					else if (char_code != "*") nphase = PH_BLOCK_CMT;
				end
				PH_STR: begin
					nlen = sat_inc(len_q);
					if (char_code == "\\") nphase = PH_STR_ESC;
					else if (char_code == "\"") begin
						p_v = 1'b1;
						p_type = T_STR;
						p_len = sat_inc(len_q);
						nphase = PH_IDLE;
					end
				end
				PH_STR_ESC: begin
					nlen = sat_inc(len_q);
					nphase = PH_STR;
				end
				PH_CHR_OPEN: begin
					nlen = sat_inc(len_q);
					nphase = (char_code == "\\") ? PH_CHR_ESC : PH_CHR_CLOSE;
				end
				PH_CHR_ESC: begin
					nlen = sat_inc(len_q);
					nphase = PH_CHR_CLOSE;
				end
				PH_CHR_CLOSE: begin
					if (char_code == "'") begin
						nlen = sat_inc(len_q);
						p_v = 1'b1;
						p_type = T_CHR;
						p_len = sat_inc(len_q);
						nphase = PH_IDLE;
					end else begin
						p_v = 1'b1;
						p_type = T_BAD_CHR;
						restart = 1'b1;
					end
				end
				default: restart = 1'b1;
			endcase
			if (restart) begin
				nphase = PH_IDLE;
				ntsl = line_q;
				ntsc = col_q;
				nlen = PosW'(1);
				if (char_code == " " || char_code == 8'h09 || char_code == 8'h0D ||
						char_code == 8'h0A) begin
					nphase = PH_IDLE;
				end else if (is_alpha(char_code)) begin
					kw_we = 1'b1;
					kw_idx = '0;
					nphase = PH_IDENT;
				end else if (is_digit(char_code)) begin
					nphase = PH_INT;
				end else if (char_code == "\"") begin
					nphase = PH_STR;
				end else if (char_code == "'") begin
					nphase = PH_CHR_OPEN;
				end else if (char_code == "+" || char_code == "-" || char_code == "=" ||
						char_code == "!" || char_code == "<" || char_code == ">" ||
						char_code == "&" || char_code == "|" || char_code == "/") begin
					nheld = char_code;
					nphase = PH_OP;
				end else begin
					t_v = 1'b1;
					t_tok = '{ttype: single_code(char_code), line: line_q, col: col_q,
						len: PosW'(1), last: 1'b0};
				end
			end
			if (char_code == 8'h0A) begin
				nline = sat_inc(line_q);
				ncol = PosW'(1);
			end else begin
				ncol = sat_inc(col_q);
			end
		end
	end

	always_comb begin
		slot = '0;
		n = '0;
		if (p_v) begin
			slot[n] = '{ttype: p_type, line: tsl_q, col: tsc_q, len: p_len, last: 1'b0};
			n = n + 2'd1;
		end
		if (d_v) begin
			slot[n] = '{ttype: T_DOT, line: tsl_q, col: dot_col, len: PosW'(1), last: 1'b0};
			n = n + 2'd1;
		end
		if (t_v) begin
			slot[n] = t_tok;
			n = n + 2'd1;
		end
		if (n != 2'd0) slot[n - 2'd1].last = 1'b1;
		push.tok = slot;
		push.num = accept ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q <= '0;
			line_q <= PosW'(1);
			col_q <= PosW'(1);
		end else if (accept) begin
			phase_q <= nphase;
			len_q <= nlen;
			line_q <= nline;
			col_q <= ncol;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tsl_q <= ntsl;
			tsc_q <= ntsc;
			held_q <= nheld;
			if (kw_we) kw_q[kw_idx] <= char_code;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/ctll_queue.sv
// Token queue between front and back: up to three pushes and one pop per cycle.
`default_nettype none
module ctll_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire ctll_pkg::push_t push,
	input wire logic pop,
	output ctll_pkg::tok_t head,
	output logic nonempty,
	output logic room
);
	import ctll_pkg::*;

	tok_t mem_q [QDepth];
	logic [QPtrW-1:0] wr_q, rd_q;
	logic [QCntW-1:0] cnt_q;

	assign head = mem_q[rd_q];
	assign nonempty = cnt_q != '0;
	assign room = cnt_q <= QCntW'(QDepth - 3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + QPtrW'(push.num);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + QCntW'(push.num) - QCntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (k < int'(push.num)) mem_q[wr_q + QPtrW'(k)] <= push.tok[k];
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/ctll_back.sv
// Back part: takes tokens from the queue into the output register.
`default_nettype none
module ctll_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire ctll_pkg::tok_t head,
	input wire logic nonempty,
	output logic pop,
	output logic tok_valid,
	input wire logic tok_stall,
	output ctll_pkg::tok_t tok
);
	import ctll_pkg::*;

	logic valid_q;
	tok_t tok_q;

	assign pop = nonempty && (!valid_q || !tok_stall);
	assign tok_valid = valid_q;
	assign tok = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (!valid_q || !tok_stall) valid_q <= nonempty;
	end

	always_ff @(posedge clk) begin
		if (pop) tok_q <= head;
	end
endmodule
`default_nettype wire

>>> hw/rtl/c_like_token_lexer.sv
// Top level of the streaming maximal-munch token lexer.
// Source bytes enter on the src channel (src_valid, src_stall, char_code, mode); a beat
// with mode high marks end of source and flushes the pending token and an end-of-file.
// Tokens leave on the tok channel (tok_valid, tok_stall) with type, start line, start
// column, length and last, which marks the final token caused by one input beat.
// One source beat is taken every cycle while src_stall is low. A beat causes zero to
// three tokens; the output register sends one token per cycle while tok_stall is low, so
// sustained rate is one beat per cycle while beats average at most one token each.
// A token closed by an accepted beat is written into the queue and then taken into
// the output register. An eight-entry queue parts the scanner from the output
// register; src_stall rises when fewer than three entries are free.
// When the receiver stalls, the output token holds and the queue fills, then
// the source side is stalled. Reset empties the queue and the output register
// and puts the scanner between tokens at line one, column one.
`default_nettype none
module c_like_token_lexer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic src_valid,
	output logic src_stall,
	input wire logic [7:0] char_code,
	input wire logic mode,
	output logic tok_valid,
	input wire logic tok_stall,
	output logic [6:0] token_type,
	output logic [ctll_pkg::PosW-1:0] start_line,
	output logic [ctll_pkg::PosW-1:0] start_column,
	output logic [ctll_pkg::PosW-1:0] token_length,
	output logic last
);
	import ctll_pkg::*;

	push_t push;
	tok_t head, tok;
	logic nonempty, room, pop;

	ctll_front u_front (
		.clk(clk), .arst_n(arst_n), .src_valid(src_valid), .src_stall(src_stall),
		.char_code(char_code), .mode(mode), .room(room), .push(push)
	);

	ctll_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .pop(pop), .head(head),
		.nonempty(nonempty), .room(room)
	);

	ctll_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .nonempty(nonempty), .pop(pop),
		.tok_valid(tok_valid), .tok_stall(tok_stall), .tok(tok)
	);

	assign token_type = tok.ttype;
	assign start_line = tok.line;
	assign start_column = tok.col;
	assign token_length = tok.len;
	assign last = tok.last;
endmodule
`default_nettype wire

>>> hw/rtl/ctll_checker.sv
// Port-level checker for the lexer and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module ctll_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic tok_valid,
	input wire logic tok_stall,
	input wire logic [6:0] token_type,
	input wire logic [ctll_pkg::PosW-1:0] start_line,
	input wire logic [ctll_pkg::PosW-1:0] start_column,
	input wire logic [ctll_pkg::PosW-1:0] token_length,
	input wire logic last
);
	import ctll_pkg::*;

	`CTLL_ASSERT_NXT(a_hold_valid, tok_valid && tok_stall, tok_valid, "token dropped while stalled")
	`CTLL_ASSERT_NXT(a_hold_type, tok_valid && tok_stall, $stable(token_type), "token changed while stalled")
	`CTLL_ASSERT_IMP(a_eof_shape, tok_valid && token_type == T_EOF, token_length == '0 && last, "bad end-of-file token")
	`CTLL_ASSERT_IMP(a_pos_nonzero, tok_valid, start_line != '0 && start_column != '0, "token position is zero")
endmodule

bind c_like_token_lexer ctll_checker u_ctll_checker (.*);
`default_nettype wire
